// ===== rtl/core/tcw_pkg.sv =====
// tcw_pkg: shared types, codes and sizes of the text console character writer
// no dependencies; imported by every module of the block

package tcw_pkg;

    // window and row geometry
    localparam int CELL_W       = 14;
    localparam int POS_W        = CELL_W;
    localparam int WINDOW_CELLS = 1 << POS_W;
    localparam int ROW_CELLS    = 80;
    localparam int ROW_W        = $clog2(WINDOW_CELLS / ROW_CELLS + 1);

    // row = (pos * MAGIC) >> MAG_SHIFT, exact for every pos below WINDOW_CELLS
    localparam int MAG_SHIFT = POS_W + $clog2(ROW_CELLS);
    localparam int MAGIC_W   = POS_W + 1;
    localparam int PROD_W    = POS_W + MAGIC_W;
    localparam longint MAGIC = ((64'd1 << MAG_SHIFT) + ROW_CELLS - 1) / ROW_CELLS;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;

    // request types
    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_ADV  = 2'd2;
    localparam logic [1:0] REQ_BACK = 2'd3;

    // character codes
    localparam logic [7:0] CODE_BACK    = 8'h05;
    localparam logic [7:0] CODE_TAB     = 8'h09;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;

    // result kinds
    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    // configuration register indexes
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        char_code;
        logic [CELL_W-1:0] new_position;
    } t_request;

    typedef struct packed {
        logic              item_kind;
        logic [CELL_W-1:0] cell_index;
        logic [7:0]        cell_char;
        logic [7:0]        attr_value;
        logic              attr_enable;
        logic [5:0]        cursor_high;
        logic [7:0]        cursor_low;
        logic              last_item;
    } t_result;

    // one classified request: up to two cell writes, then the cursor report
    typedef struct packed {
        logic [1:0]       n_cells;
        logic [POS_W-1:0] idx0;
        logic [7:0]       char0;
        logic             aen0;
        logic [POS_W-1:0] idx1;
        logic             aen1;
        logic [POS_W-1:0] cursor;
    } t_cmd;

endpackage

// ===== rtl/core/text_console_char_writer_top.sv =====
// text_console_char_writer_top: console character writer, top level
// depends on tcw_pkg, tcw_front, tcw_cmd_fifo, tcw_back
//
//  channel   direction  handshake                    payload
//  request   in         push / full                  i_req    (t_request)
//  result    out        empty / pop                  o_result (t_result)
//  config    in         psel penable pwrite pready   pwdata / prdata, paddr
//
// a request yields zero to three results, one per cycle while results are
// popped (control codes below backspace yield none); the back expander's
// single output slot sets that rate, and a newline holds the front in its
// FS_ROW and FS_PUSH states for the row computation (cursor times a row
// reciprocal, then back times the row length)
// synchronous active-low reset clears cursor, queue, state and text_attr;
// the command queue lets the front keep taking requests while results stall

module text_console_char_writer_top #(
    parameter int CMD_DEPTH = tcw_pkg::CMD_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              push,
    output logic              full,
    input  tcw_pkg::t_request i_req,
    // result channel
    output logic              empty,
    input  logic              pop,
    output tcw_pkg::t_result  o_result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcw_pkg::*;

    logic [7:0] r_text_attr;
    logic       cfg_write;
    logic       reg_idx;

    logic  q_push, q_full, q_pop, q_empty;
    t_cmd  q_in_cmd, q_out_cmd;

    // configuration register, one 32-bit slot per register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= '0;
        end else if (cfg_write && reg_idx == REG_TEXT_ATTR) begin
            r_text_attr <= pwdata[7:0];
        end
    end

    // reads beyond the register list return zero
    assign prdata = (reg_idx == REG_TEXT_ATTR) ? {24'd0, r_text_attr} : 32'd0;

    // front: accept, keep the cursor, classify into commands
    tcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_req    (i_req),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd),
        .i_q_full (q_full)
    );

    // short decoupling queue
    tcw_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // back: expand commands into cell writes and the cursor report
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_cmd       (q_out_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== rtl/core/tcw_front.sv =====
// tcw_front: accepts requests, keeps the cursor and classifies each request
// into a command; depends on tcw_pkg

module tcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  tcw_pkg::t_request i_req,
    output logic              o_q_push,
    output tcw_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_full
);
    import tcw_pkg::*;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_ROW  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    localparam logic [MAGIC_W-1:0] MAGIC_V     = MAGIC_W'(MAGIC);
    localparam logic [POS_W-1:0]   ROW_CELLS_P = POS_W'(ROW_CELLS);

    logic [1:0]        r_state, n_state;
    logic [POS_W-1:0]  r_cursor;
    logic [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]  r_row_start;
    logic [ROW_W-1:0]  row_q;

    logic  accept;
    logic  is_nl;
    logic  is_ignored;
    t_cmd  imm_cmd;
    t_cmd  nl_cmd;
    logic [POS_W-1:0] p;

    assign p      = r_cursor;
    assign accept = i_push && (r_state == FS_IDLE) && !i_q_full;
    assign o_full = !((r_state == FS_IDLE) && !i_q_full);
    assign row_q  = r_prod[MAG_SHIFT +: ROW_W];

    always_comb begin
        imm_cmd         = '0;
        imm_cmd.idx0    = p;
        imm_cmd.char0   = CHAR_BLANK;
        imm_cmd.idx1    = p + POS_W'(1);
        imm_cmd.cursor  = p;
        is_nl           = 1'b0;
        is_ignored      = 1'b0;
        unique case (i_req.req_type)
            REQ_SET:  imm_cmd.cursor = POS_W'(i_req.new_position);
            REQ_ADV:  imm_cmd.cursor = p + POS_W'(1);
            REQ_BACK: imm_cmd.cursor = p - POS_W'(1);
            REQ_PUT: begin
                priority if (i_req.char_code < CODE_BACK) begin
                    is_ignored = 1'b1;
                end else if (i_req.char_code == CODE_NEWLINE) begin
                    is_nl = 1'b1;
                end else if (i_req.char_code == CODE_TAB) begin
                    imm_cmd.n_cells = 2'd2;
                    imm_cmd.aen0    = 1'b1;
                    imm_cmd.cursor  = p + POS_W'(3);
                end else if (i_req.char_code == CODE_BACK && p != '0) begin
                    imm_cmd.n_cells = 2'd2;
                    imm_cmd.idx0    = p - POS_W'(1);
                    imm_cmd.idx1    = p;
                    imm_cmd.aen1    = 1'b1;
                    imm_cmd.cursor  = p - POS_W'(1);
                end else begin
                    imm_cmd.n_cells = 2'd1;
                    imm_cmd.char0   = i_req.char_code;
                    imm_cmd.aen0    = 1'b1;
                    imm_cmd.cursor  = p + POS_W'(1);
                end
            end
            default: imm_cmd.cursor = p;
        endcase
    end

    // newline: blank the last cell of the row above, go to the next row start
    always_comb begin
        nl_cmd         = '0;
        nl_cmd.n_cells = (r_row_start != '0) ? 2'd1 : 2'd0;
        nl_cmd.idx0    = r_row_start - POS_W'(1);
        nl_cmd.char0   = CHAR_BLANK;
        nl_cmd.idx1    = r_row_start;
        nl_cmd.cursor  = r_row_start + ROW_CELLS_P;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (accept && is_nl) n_state = FS_ROW;
            FS_ROW:  n_state = FS_PUSH;
            FS_PUSH: if (!i_q_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_q_push = (accept && !is_ignored && !is_nl) ||
                      ((r_state == FS_PUSH) && !i_q_full);
    assign o_q_cmd  = (r_state == FS_PUSH) ? nl_cmd : imm_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_cursor <= '0;
        end else begin
            r_state <= n_state;
            if (accept && !is_nl) begin
                r_cursor <= imm_cmd.cursor;
            end else if ((r_state == FS_PUSH) && !i_q_full) begin
                r_cursor <= nl_cmd.cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= PROD_W'(r_cursor) * PROD_W'(MAGIC_V);
        end
        if (r_state == FS_ROW) begin
            r_row_start <= POS_W'(row_q) * ROW_CELLS_P;
        end
    end

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != FS_IDLE) |-> o_full)
        else $error("front takes a request while a newline is in work");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH) |->
            (r_row_start <= r_cursor) && ((r_cursor - r_row_start) < ROW_CELLS_P))
        else $error("newline row start does not hold the cursor row");

endmodule

// ===== rtl/core/tcw_cmd_fifo.sv =====
// tcw_cmd_fifo: short command queue between front and back
// depends on tcw_pkg for the command type

module tcw_cmd_fifo #(
    parameter int DEPTH = tcw_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import tcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("command queue count overflow");

endmodule

// ===== rtl/core/tcw_back.sv =====
// tcw_back: expands commands into cell writes and a cursor report, one
// result per cycle into an output register unless pop stalls; needs tcw_pkg

module tcw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_text_attr,
    input  tcw_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output tcw_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);
    import tcw_pkg::*;

    t_cmd       r_cmd;
    logic       r_active;
    logic [1:0] r_step;
    t_result    r_out;
    logic       r_out_valid;

    logic       out_ready;
    logic       is_last;
    logic       emit;
    t_result    item;

    assign out_ready = !r_out_valid || i_pop;
    assign is_last   = (r_step == r_cmd.n_cells);
    assign emit      = r_active && out_ready;
    assign o_cmd_pop = !i_cmd_empty && (!r_active || (emit && is_last));
    assign o_result  = r_out;
    assign o_empty   = !r_out_valid;

    always_comb begin
        item = '0;
        if (is_last) begin
            item.item_kind   = KIND_CURSOR;
            item.cursor_high = r_cmd.cursor[POS_W-1:8];
            item.cursor_low  = r_cmd.cursor[7:0];
            item.last_item   = 1'b1;
        end else if (r_step == 2'd0) begin
            item.item_kind   = KIND_CELL;
            item.cell_index  = r_cmd.idx0;
            item.cell_char   = r_cmd.char0;
            item.attr_enable = r_cmd.aen0;
            item.attr_value  = r_cmd.aen0 ? i_text_attr : 8'd0;
        end else begin
            item.item_kind   = KIND_CELL;
            item.cell_index  = r_cmd.idx1;
            item.cell_char   = CHAR_BLANK;
            item.attr_enable = r_cmd.aen1;
            item.attr_value  = r_cmd.aen1 ? i_text_attr : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (emit && is_last) begin
                r_active <= 1'b0;
            end else if (emit) begin
                r_step <= r_step + 2'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out <= item;
        end
    end

    a_last_is_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last_item == (r_out.item_kind == KIND_CURSOR)))
        else $error("last result of a request is not the cursor report");

endmodule
